>>> rtl/core/awss_pkg.sv
// awss_pkg: shared types and codes for the active worker skip scheduler
// no dependencies; used by every file in rtl/core
package awss_pkg;

  localparam int unsigned ActionW = 2;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned VoiceW  = 4;
  localparam int unsigned SampleW = 16;
  localparam int unsigned LenW    = 6;

  localparam logic [ActionW-1:0] ACT_LOAD      = 2'd0;
  localparam logic [ActionW-1:0] ACT_VOICE_ON  = 2'd1;
  localparam logic [ActionW-1:0] ACT_VOICE_OFF = 2'd2;
  localparam logic [ActionW-1:0] ACT_RENDER    = 2'd3;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [SlotW-1:0]   slot_index;
    logic               slot_unassigned;
    logic [VoiceW-1:0]  slot_voice;
    logic               slot_is_final;
    logic [VoiceW-1:0]  voice_number;
    logic [SampleW-1:0] sample_count;
  } awss_item_t;

  typedef struct packed {
    logic [SlotW-1:0]   worker_index;
    logic [SampleW-1:0] samples;
    logic               last_of_run;
  } awss_result_t;

  typedef struct packed {
    logic              free;
    logic [VoiceW-1:0] owner;
  } awss_slot_t;

endpackage

>>> rtl/core/awss_slot_ram.sv
// awss_slot_ram: slot assignment memory, one write and one registered read port
// depends on awss_pkg for the slot word type
module awss_slot_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  awss_pkg::awss_slot_t wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output awss_pkg::awss_slot_t rdata_o
);

  awss_pkg::awss_slot_t mem_q [Depth];
  awss_pkg::awss_slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/awss_skip_ram.sv
// awss_skip_ram: skip distance memory with per-entry valid bits, registered read
// invalid entries read as one; depends on awss_pkg for widths
module awss_skip_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [awss_pkg::LenW-1:0] wdata_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [awss_pkg::LenW-1:0] rdata_o
);

  logic [awss_pkg::LenW-1:0] mem_q [Depth];
  logic [Depth-1:0]          valid_q;
  logic [awss_pkg::LenW-1:0] rdata_q;
  logic                      rvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q  <= mem_q[raddr_i];
    rvalid_q <= valid_q[raddr_i];
  end

  assign rdata_o = rvalid_q ? rdata_q : awss_pkg::LenW'(1);

endmodule

>>> rtl/core/active_worker_skip_scheduler_top.sv
// Load and voice items are taken in the idle state and busy stays low. A render item keeps
// busy high while a sequencer rebuilds a stale skip table, a read and a write state for
// each slot from the last one down to slot one, plus a read and a write state for the
// start slot, and then walks the table: a check state, then for each emitted worker one
// skip memory read and one add on the shared adder. The last result of a walk shows in
// the first cycle in which busy is low again. Each result is shown for exactly one cycle
// on res_o with res_valid_o high; the receiver cannot stall and must take it.
//
// active_worker_skip_scheduler_top: sequencer, voice bits and shared adder
// depends on awss_pkg, awss_slot_ram, awss_skip_ram
module active_worker_skip_scheduler_top #(
  parameter int unsigned SLOT_COUNT  = 32,
  parameter int unsigned VOICE_COUNT = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  awss_pkg::awss_item_t   item_i,
  output logic                   res_valid_o,
  output awss_pkg::awss_result_t res_o
);

  localparam int unsigned SidxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned VidxW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned LenW  = awss_pkg::LenW;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RB_RD   = 3'd1;
  localparam logic [2:0] S_RB_WR   = 3'd2;
  localparam logic [2:0] S_ST_RD   = 3'd3;
  localparam logic [2:0] S_ST_WR   = 3'd4;
  localparam logic [2:0] S_WK_CHK  = 3'd5;
  localparam logic [2:0] S_WK_RD   = 3'd6;
  localparam logic [2:0] S_WK_EMIT = 3'd7;

  logic [2:0]                    state_q, state_d;
  logic [LenW-1:0]               len_q, len_d;
  logic [LenW-1:0]               start_slot_q, start_slot_d;
  logic [LenW-1:0]               cnt_q, cnt_d;
  logic [LenW-1:0]               carry_q, carry_d;
  logic                          armed_q, armed_d;
  logic                          stale_q, stale_d;
  logic [VOICE_COUNT-1:0]        voice_q, voice_d;
  logic [awss_pkg::SampleW-1:0]  samples_q, samples_d;
  logic                          out_valid_q, out_valid_d;
  awss_pkg::awss_result_t        out_q, out_d;

  logic                          accept;
  logic                          slot_ok;
  logic                          voice_ok;
  logic                          slot_we;
  awss_pkg::awss_slot_t          slot_wdata;
  awss_pkg::awss_slot_t          slot_rdata;
  logic                          skip_clear;
  logic                          skip_we;
  logic [LenW-1:0]               skip_wdata;
  logic [LenW-1:0]               skip_rdata;
  logic [LenW-1:0]               cnt_dec;
  logic                          runs;
  logic                          owner_ok;
  logic [LenW-1:0]               add_a, add_b, add_sum;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign slot_ok  = (32'(item_i.slot_index) < SLOT_COUNT);
  assign voice_ok = (32'(item_i.voice_number) < VOICE_COUNT);
  assign owner_ok = (32'(slot_rdata.owner) < VOICE_COUNT);
  assign runs     = slot_rdata.free ||
                    (owner_ok && voice_q[VidxW'(slot_rdata.owner)]);

  // shared adder: skip + 1 while rebuilding, index + step while walking
  assign add_a   = (state_q == S_WK_EMIT) ? cnt_q : carry_q;
  assign add_b   = (state_q == S_WK_EMIT) ? skip_rdata : LenW'(1);
  assign add_sum = add_a + add_b;
  assign cnt_dec = cnt_q - LenW'(1);

  assign slot_we         = accept && (item_i.action == awss_pkg::ACT_LOAD) && slot_ok;
  assign slot_wdata.free  = item_i.slot_unassigned;
  assign slot_wdata.owner = item_i.slot_voice;
  assign skip_clear      = slot_we && item_i.slot_is_final;
  assign skip_we         = (state_q == S_RB_WR);
  assign skip_wdata      = runs ? LenW'(1) : add_sum;

  awss_slot_ram #(
    .Depth (SLOT_COUNT),
    .AddrW (SidxW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (SidxW'(item_i.slot_index)),
    .wdata_i (slot_wdata),
    .raddr_i (SidxW'(cnt_q)),
    .rdata_o (slot_rdata)
  );

  awss_skip_ram #(
    .Depth (SLOT_COUNT),
    .AddrW (SidxW)
  ) u_skip_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (skip_clear),
    .we_i    (skip_we),
    .waddr_i (SidxW'(cnt_dec)),
    .wdata_i (skip_wdata),
    .raddr_i (SidxW'(cnt_q)),
    .rdata_o (skip_rdata)
  );

  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    start_slot_d = start_slot_q;
    cnt_d        = cnt_q;
    carry_d      = carry_q;
    armed_d      = armed_q;
    stale_d      = stale_q;
    voice_d      = voice_q;
    samples_d    = samples_q;
    out_valid_d  = 1'b0;
    out_d        = out_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (item_i.action)
            awss_pkg::ACT_LOAD: begin
              if (slot_ok && item_i.slot_is_final) begin
                len_d   = LenW'(item_i.slot_index) + LenW'(1);
                armed_d = 1'b1;
                stale_d = 1'b1;
              end
            end
            awss_pkg::ACT_VOICE_ON, awss_pkg::ACT_VOICE_OFF: begin
              if (voice_ok) begin
                voice_d[VidxW'(item_i.voice_number)] =
                  (item_i.action == awss_pkg::ACT_VOICE_ON);
                if (armed_q) begin
                  stale_d = 1'b1;
                end
              end
            end
            default: begin
              samples_d = item_i.sample_count;
              stale_d   = 1'b0;
              if (stale_q && (len_q != '0)) begin
                cnt_d   = len_q - LenW'(1);
                carry_d = LenW'(1);
                state_d = (len_q == LenW'(1)) ? S_ST_RD : S_RB_RD;
              end else if (armed_q) begin
                cnt_d   = start_slot_q;
                state_d = S_WK_CHK;
              end
            end
          endcase
        end
      end
      S_RB_RD: begin
        state_d = S_RB_WR;
      end
      S_RB_WR: begin
        carry_d = skip_wdata;
        cnt_d   = cnt_dec;
        state_d = (cnt_dec == '0) ? S_ST_RD : S_RB_RD;
      end
      S_ST_RD: begin
        state_d = S_ST_WR;
      end
      S_ST_WR: begin
        start_slot_d = runs ? '0 : carry_q;
        cnt_d        = runs ? '0 : carry_q;
        state_d      = armed_q ? S_WK_CHK : S_IDLE;
      end
      S_WK_CHK: begin
        state_d = (cnt_q < len_q) ? S_WK_RD : S_IDLE;
      end
      S_WK_RD: begin
        state_d = S_WK_EMIT;
      end
      S_WK_EMIT: begin
        out_valid_d        = 1'b1;
        out_d.worker_index = cnt_q[awss_pkg::SlotW-1:0];
        out_d.samples      = samples_q;
        out_d.last_of_run  = (add_sum >= len_q);
        cnt_d              = add_sum;
        state_d            = (add_sum >= len_q) ? S_IDLE : S_WK_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      len_q        <= '0;
      start_slot_q <= '0;
      cnt_q        <= '0;
      carry_q      <= LenW'(1);
      armed_q      <= 1'b0;
      stale_q      <= 1'b0;
      voice_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      len_q        <= len_d;
      start_slot_q <= start_slot_d;
      cnt_q        <= cnt_d;
      carry_q      <= carry_d;
      armed_q      <= armed_d;
      stale_q      <= stale_d;
      voice_q      <= voice_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samples_q <= samples_d;
    out_q     <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule
